@@ design/button_click_classifier_macros.svh @@
// ----------------------------------------------------------------------------
// Button click classifier assertion macros
// Shared concurrent assertion forms for the block's checker.
// ----------------------------------------------------------------------------
`ifndef BUTTON_CLICK_CLASSIFIER_MACROS_SVH
`define BUTTON_CLICK_CLASSIFIER_MACROS_SVH

// Same-cycle implication: when the antecedent holds, the consequent holds.
`define BCC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("button click classifier: same-cycle check failed");

// Next-cycle implication: when the antecedent holds, the consequent holds in the next cycle.
`define BCC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("button click classifier: next-cycle check failed");

`endif

@@ design/bcc_pkg.sv @@
// ----------------------------------------------------------------------------
// Button click classifier package
// Widths, register indexes, reset values and shared types.
// ----------------------------------------------------------------------------
package bcc_pkg;

    // Field widths.
    localparam int PIN_W   = 4;
    localparam int LED_W   = 2 * PIN_W;
    localparam int DEB_W   = 4;
    localparam int TICK_W  = 16;
    localparam int CLICK_W = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Default number of buttons served.
    localparam int NUM_BUTTONS_DEFAULT = 4;

    // Saturation limits.
    localparam logic [DEB_W-1:0]   DEB_MAX   = '1;
    localparam logic [TICK_W-1:0]  TICK_MAX  = '1;
    localparam logic [CLICK_W-1:0] CLICK_MAX = '1;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_DEBOUNCE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_LONG     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_GAP      = 2'd2;

    // Register reset values.
    localparam logic [DEB_W-1:0]  DEBOUNCE_RESET = 4'd3;
    localparam logic [TICK_W-1:0] LONG_RESET     = 16'd30;
    localparam logic [TICK_W-1:0] GAP_RESET      = 16'd15;

    // Configuration seen by every button.
    typedef struct packed {
        logic [DEB_W-1:0]  debounce_samples;
        logic [TICK_W-1:0] long_press_ticks;
        logic [TICK_W-1:0] click_gap_ticks;
    } t_cfg;

    // Events one button reports for one tick.
    typedef struct packed {
        logic long_press;
        logic single_click;
        logic double_click;
    } t_btn_ev;

endpackage

@@ design/bcc_button.sv @@
// ----------------------------------------------------------------------------
// Button click classifier, one button
// Debounces one raw level and classifies presses into long, single and double.
// ----------------------------------------------------------------------------
module bcc_button (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_step,
    input  logic            i_raw,
    input  bcc_pkg::t_cfg   i_cfg,
    output bcc_pkg::t_btn_ev o_ev
);
    import bcc_pkg::*;

    typedef enum logic [1:0] {
        PH_IDLE     = 2'd0,
        PH_PRESSED  = 2'd1,
        PH_RELEASED = 2'd2
    } t_phase;

    logic               r_stable, n_stable;
    logic [DEB_W-1:0]   r_deb, n_deb;
    logic [TICK_W-1:0]  r_held, n_held;
    t_phase             r_phase, n_phase;
    logic [CLICK_W-1:0] r_click, n_click;
    t_btn_ev            n_ev;
    logic [DEB_W-1:0]   deb_inc;
    logic [TICK_W-1:0]  held_inc;

    // One tick of debounce and classification.
    always_comb begin
        n_ev     = '0;
        n_stable = r_stable;
        n_click  = r_click;
        n_phase  = r_phase;

        // The tick counter runs in every phase but idle.
        held_inc = r_held;
        if (r_phase != PH_IDLE && r_held != TICK_MAX) begin
            held_inc = r_held + 1'b1;
        end
        n_held = held_inc;

        // A level change is taken after enough differing samples in a row.
        deb_inc = r_deb;
        if (r_stable != i_raw) begin
            if (r_deb != DEB_MAX) begin
                deb_inc = r_deb + 1'b1;
            end
            if (deb_inc >= i_cfg.debounce_samples) begin
                n_stable = i_raw;
                n_deb    = '0;
            end else begin
                n_deb    = deb_inc;
            end
        end else begin
            n_deb = '0;
        end

        case (r_phase)
            PH_PRESSED: begin
                if (n_stable) begin
                    if (held_inc >= i_cfg.long_press_ticks) begin
                        n_ev.long_press = 1'b1;
                        n_phase         = PH_IDLE;
                    end else begin
                        n_held  = '0;
                        n_phase = PH_RELEASED;
                    end
                end else if (held_inc >= i_cfg.long_press_ticks) begin
                    n_click = '0;
                end
            end
            PH_RELEASED: begin
                if (held_inc >= i_cfg.click_gap_ticks) begin
                    n_phase = PH_IDLE;
                    if (r_click == 2'd1) begin
                        n_ev.single_click = 1'b1;
                    end else if (r_click == 2'd2) begin
                        n_ev.double_click = 1'b1;
                    end
                end else if (!n_stable) begin
                    if (r_click != CLICK_MAX) begin
                        n_click = r_click + 1'b1;
                    end
                    n_held  = '0;
                    n_phase = PH_PRESSED;
                end
            end
            default: begin
                n_phase = PH_IDLE;
                if (!n_stable) begin
                    n_held  = '0;
                    n_click = 2'd1;
                    n_phase = PH_PRESSED;
                end
            end
        endcase
    end

    assign o_ev = n_ev;

    // Per-button state, advanced once per processed tick.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stable <= 1'b1;
            r_deb    <= '0;
            r_held   <= '0;
            r_phase  <= PH_IDLE;
            r_click  <= '0;
        end else if (i_step) begin
            r_stable <= n_stable;
            r_deb    <= n_deb;
            r_held   <= n_held;
            r_phase  <= n_phase;
            r_click  <= n_click;
        end
    end

endmodule

@@ design/button_click_classifier.sv @@
// ----------------------------------------------------------------------------
// Button click classifier
// Debounces up to four active-low buttons and reports long, single and double
// presses, toggling an eight-bit indicator pattern.
// ----------------------------------------------------------------------------
// Each input word is one sampling tick and yields exactly one result word. A
// word is registered on entry, classified by one pass of per-button logic and
// held in the result register; one word per clock is sustained while the
// result is not stalled, as set by that single pass through the button logic.
// The input side stalls only while both the entry and result registers are
// full and the result is stalled. Registers (debounce samples, long press
// ticks, click gap ticks) are written via the always-ready configuration port;
// the user must do so while no word is in flight; the block does not check it.
module button_click_classifier #(
    parameter int NUM_BUTTONS = bcc_pkg::NUM_BUTTONS_DEFAULT
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Input channel.
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [bcc_pkg::PIN_W-1:0]      i_pin_levels,
    // Result channel.
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [bcc_pkg::LED_W-1:0]      o_led_pattern,
    output logic [bcc_pkg::PIN_W-1:0]      o_long_press_events,
    output logic [bcc_pkg::PIN_W-1:0]      o_single_click_events,
    output logic [bcc_pkg::PIN_W-1:0]      o_double_click_events,
    // Configuration write channel.
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [bcc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bcc_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import bcc_pkg::*;

    t_cfg             r_cfg;
    logic             r_in_valid;
    logic [PIN_W-1:0] r_pins;
    logic             r_out_valid;
    logic [LED_W-1:0] r_led, n_led;
    logic [PIN_W-1:0] r_ev_long, r_ev_single, r_ev_double;
    logic [PIN_W-1:0] ev_long, ev_single, ev_double;
    logic             out_load, step, in_load;

    // Pipeline flow: the result register frees when empty or taken.
    assign out_load = !r_out_valid || !i_stall;
    assign step     = r_in_valid && out_load;
    assign in_load  = !r_in_valid || out_load;
    assign o_stall  = !in_load;
    assign o_valid  = r_out_valid;
    assign o_cfg_ready = 1'b1;

    // Configuration registers; unknown indexes are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_samples <= DEBOUNCE_RESET;
            r_cfg.long_press_ticks <= LONG_RESET;
            r_cfg.click_gap_ticks  <= GAP_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_IDX_DEBOUNCE: r_cfg.debounce_samples <= i_cfg_data[DEB_W-1:0];
                CFG_IDX_LONG:     r_cfg.long_press_ticks <= i_cfg_data[TICK_W-1:0];
                CFG_IDX_GAP:      r_cfg.click_gap_ticks  <= i_cfg_data[TICK_W-1:0];
                default:          ;
            endcase
        end
    end

    // Per-button classifiers; absent buttons report nothing.
    for (genvar b = 0; b < PIN_W; b++) begin : g_btn
        if (b < NUM_BUTTONS) begin : g_used
            t_btn_ev ev;
            bcc_button u_button (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_step  (step),
                .i_raw   (r_pins[b]),
                .i_cfg   (r_cfg),
                .o_ev    (ev)
            );
            assign ev_long[b]   = ev.long_press;
            assign ev_single[b] = ev.single_click;
            assign ev_double[b] = ev.double_click;
        end else begin : g_unused
            assign ev_long[b]   = 1'b0;
            assign ev_single[b] = 1'b0;
            assign ev_double[b] = 1'b0;
        end
    end

    // Long and double presses toggle the low bit, single clicks the high bit.
    always_comb begin
        n_led = r_led;
        for (int b = 0; b < PIN_W; b++) begin
            n_led[b]         = r_led[b] ^ (ev_long[b] | ev_double[b]);
            n_led[b + PIN_W] = r_led[b + PIN_W] ^ ev_single[b];
        end
    end

    // Entry register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_load) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_load && i_valid) begin
            r_pins <= i_pin_levels;
        end
    end

    // Result register and indicator pattern.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_led       <= '0;
        end else begin
            if (out_load) begin
                r_out_valid <= r_in_valid;
            end
            if (step) begin
                r_led <= n_led;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_ev_long   <= ev_long;
            r_ev_single <= ev_single;
            r_ev_double <= ev_double;
        end
    end

    assign o_led_pattern         = r_led;
    assign o_long_press_events   = r_ev_long;
    assign o_single_click_events = r_ev_single;
    assign o_double_click_events = r_ev_double;

endmodule

@@ design/bcc_checker.sv @@
// ----------------------------------------------------------------------------
// Button click classifier checker
// Port-level assertions on flow control and event reporting.
// ----------------------------------------------------------------------------
`include "button_click_classifier_macros.svh"

module bcc_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           o_stall,
    input logic                           o_valid,
    input logic                           i_stall,
    input logic [bcc_pkg::LED_W-1:0]      o_led_pattern,
    input logic [bcc_pkg::PIN_W-1:0]      o_long_press_events,
    input logic [bcc_pkg::PIN_W-1:0]      o_single_click_events,
    input logic [bcc_pkg::PIN_W-1:0]      o_double_click_events,
    input logic                           i_cfg_valid,
    input logic                           o_cfg_ready
);

    logic ev_clash;
    logic [bcc_pkg::LED_W+3*bcc_pkg::PIN_W-1:0] result_word;

    // Any button reporting two kinds of event at once.
    assign ev_clash = |((o_long_press_events & o_single_click_events)
                      | (o_long_press_events & o_double_click_events)
                      | (o_single_click_events & o_double_click_events));

    // The whole result word, for hold checks.
    assign result_word = {o_led_pattern, o_long_press_events,
                          o_single_click_events, o_double_click_events};

    // A button reports at most one kind of event per tick.
    `BCC_ASSERT_IMP(a_one_event, i_clk, i_rst_n, o_valid, !ev_clash)

    // A stalled result word holds.
    `BCC_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(result_word))

    // The input side stalls only behind a full, stalled result register.
    `BCC_ASSERT_IMP(a_stall_cause, i_clk, i_rst_n, o_stall, o_valid && i_stall)

    // Reset empties the result register.
    `BCC_ASSERT_NXT(a_reset_empty, i_clk, 1'b1, !i_rst_n, !o_valid && !o_stall)

    // The configuration port never holds off a write.
    `BCC_ASSERT_IMP(a_cfg_ready, i_clk, i_rst_n, i_cfg_valid, o_cfg_ready)

endmodule

bind button_click_classifier bcc_checker u_bcc_checker (.*);
